// ===== design/assert_macros.svh =====
// Assertion macros used by the table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define IRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define IRT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/irt_pkg.sv =====
// Types, constants and codes of the interval reservation table.
`timescale 1ns / 1ps
package irt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam logic [26:0] MS_PER_DAY      = 27'd86400000;
  localparam logic [16:0] MIN_START_DAY   = 17'd5;
  localparam logic [26:0] LEAD_RESET      = 27'd2500;
  localparam int unsigned LIN_W           = 46;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_READ   = 3'd3,
    REQ_PURGE  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LATE  = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] ref_id;
    logic [16:0] start_day;
    logic [26:0] start_ms;
    logic [16:0] stop_day;
    logic [26:0] stop_ms;
    logic [16:0] now_day;
    logic [26:0] now_ms;
    logic [5:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_index;
    logic [31:0] out_ref;
    logic [16:0] out_start_day;
    logic [26:0] out_start_ms;
    logic [16:0] out_stop_day;
    logic [26:0] out_stop_ms;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ref_id;
    logic [16:0] start_day;
    logic [26:0] start_ms;
    logic [16:0] stop_day;
    logic [26:0] stop_ms;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_NOW_M, S_NOW_A, S_NS_M, S_NS_A, S_NE_M, S_NE_A, S_INS_CHK,
    S_SCAN_RD, S_SCAN_LD, S_BS_M, S_BS_A, S_BE_M, S_BE_A, S_SCAN_CMP,
    S_SH_RD, S_SH_WR, S_INS_WR, S_FIND_RD, S_FIND_LD, S_RM_RD, S_RM_WR,
    S_RD_RD, S_RD_LD, S_PG_CHK, S_PG_LD, S_PG_CMP, S_RESP
  } state_e;

endpackage

// ===== design/irt_req_if.sv =====
// Request channel interface.
`timescale 1ns / 1ps
interface irt_req_if;
  logic          valid;
  logic          ready;
  irt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/irt_rsp_if.sv =====
// Response channel interface.
`timescale 1ns / 1ps
interface irt_rsp_if;
  logic          valid;
  logic          ready;
  irt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/irt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module irt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/interval_reservation_table_core.sv =====
// Sorted interval reservation table: sequencer, shared time unit and entry RAM.
// Insert computes now and the padded start and stop, rejects a late request or a full
// table, then scans entries until a conflict or its place and shifts later entries up;
// remove and lookup search by reference, remove shifting later entries down; read takes a
// slot (miss past the count); purge drops late head entries in turn; other types reply OK.
// One request at a time, next taken the cycle after; reset (async, low) empties, lead 2500.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module interval_reservation_table_core #(
  parameter int unsigned MAX_ENTRIES = irt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [26:0] cfg_data_i,
  irt_req_if.sink     req_i,
  irt_rsp_if.source   rsp_o
);
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned ENT_W = $bits(irt_pkg::entry_t);
  localparam int unsigned LW    = irt_pkg::LIN_W;

  irt_pkg::state_e state_q, state_d;

  // request and table state
  irt_pkg::req_t     rq_q;
  irt_pkg::entry_t   ent_q;
  logic [26:0]       lead_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q;     // scan / search position
  logic [CNT_W-1:0]  k_q;       // shift position
  logic [CNT_W-1:0]  pos_q;     // insert position

  // linear times (day * ms_per_day + ms; starts less lead, stops plus lead)
  logic signed [LW-1:0] now_q, ns_q, ne_q, bs_q, be_q, prev_be_q;
  logic [43:0]          mul_q;
  logic [16:0]          mul_day;
  logic [26:0]          add_ms;
  logic signed [LW-1:0] lin_base, lin_sum;
  logic                 add_sub, add_add;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  irt_pkg::entry_t   ram_wdata, ram_rdata;
  logic [ENT_W-1:0]  ram_rdata_raw;

  // result
  logic              res_load;
  logic [2:0]        res_status;
  logic [5:0]        res_idx;
  irt_pkg::entry_t   res_ent;
  irt_pkg::rsp_t     rsp_q;
  irt_pkg::entry_t   new_ent;

  logic [CMP_W-1:0]  sidx_w;
  logic              read_ok, ins_late, ovl, before_b, prev_ok, ref_hit, purge_late;
  logic [CNT_W:0]    k_next;

  assign cfg_ready_o = 1'b1;
  assign req_i.ready = (state_q == irt_pkg::S_IDLE);
  assign rsp_o.valid = (state_q == irt_pkg::S_RESP);
  assign rsp_o.data  = rsp_q;

  assign new_ent = '{ref_id: rq_q.ref_id, start_day: rq_q.start_day,
                     start_ms: rq_q.start_ms, stop_day: rq_q.stop_day,
                     stop_ms: rq_q.stop_ms};

  assign sidx_w  = CMP_W'(rq_q.slot_index);
  assign read_ok = sidx_w < CMP_W'(cnt_q);
  assign k_next  = {1'b0, k_q} + 1'b1;
  assign ram_rdata = irt_pkg::entry_t'(ram_rdata_raw);
  assign ref_hit = (ram_rdata.ref_id == rq_q.ref_id);

  // too-late test: start day below minimum, or padded start before now
  assign ins_late   = (rq_q.start_day < irt_pkg::MIN_START_DAY) || (ns_q < now_q);
  assign purge_late = (ent_q.start_day < irt_pkg::MIN_START_DAY) || (bs_q < now_q);

  // overlap: an endpoint strictly inside the other interval, or equal endpoints
  assign ovl = (bs_q < ns_q && ns_q < be_q) || (bs_q < ne_q && ne_q < be_q) ||
               (ns_q < bs_q && bs_q < ne_q) || (ns_q < be_q && be_q < ne_q) ||
               (ns_q == bs_q) || (ns_q == be_q) || (ne_q == bs_q) || (ne_q == be_q);
  assign before_b = ne_q < bs_q;
  assign prev_ok  = (idx_q == '0) || (prev_be_q < ns_q);

  // shared time unit: one multiplier stage, then one add stage
  always_comb begin
    mul_day = rq_q.now_day;
    add_ms  = rq_q.now_ms;
    add_sub = 1'b0;
    add_add = 1'b0;
    case (state_q)
      irt_pkg::S_NS_M, irt_pkg::S_NS_A: begin
        mul_day = rq_q.start_day;
        add_ms  = rq_q.start_ms;
        add_sub = 1'b1;
      end
      irt_pkg::S_NE_M, irt_pkg::S_NE_A: begin
        mul_day = rq_q.stop_day;
        add_ms  = rq_q.stop_ms;
        add_add = 1'b1;
      end
      irt_pkg::S_BS_M, irt_pkg::S_BS_A: begin
        mul_day = ent_q.start_day;
        add_ms  = ent_q.start_ms;
        add_sub = 1'b1;
      end
      irt_pkg::S_BE_M, irt_pkg::S_BE_A: begin
        mul_day = ent_q.stop_day;
        add_ms  = ent_q.stop_ms;
        add_add = 1'b1;
      end
      default: ;
    endcase
  end

  assign lin_base = $signed({2'b00, mul_q}) + $signed({19'b0, add_ms});
  assign lin_sum  = add_sub ? lin_base - $signed({19'b0, lead_q}) :
                    add_add ? lin_base + $signed({19'b0, lead_q}) : lin_base;

  always_ff @(posedge clk_i) begin
    mul_q <= 44'(mul_day * irt_pkg::MS_PER_DAY);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      irt_pkg::S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.data.req_type)
            irt_pkg::REQ_INSERT, irt_pkg::REQ_PURGE: state_d = irt_pkg::S_NOW_M;
            irt_pkg::REQ_REMOVE, irt_pkg::REQ_LOOKUP: state_d = irt_pkg::S_FIND_RD;
            irt_pkg::REQ_READ: state_d = irt_pkg::S_RD_RD;
            default: state_d = irt_pkg::S_RESP;
          endcase
        end
      end
      irt_pkg::S_NOW_M: state_d = irt_pkg::S_NOW_A;
      irt_pkg::S_NOW_A: state_d = (rq_q.req_type == irt_pkg::REQ_INSERT) ?
                                  irt_pkg::S_NS_M : irt_pkg::S_PG_CHK;
      irt_pkg::S_NS_M: state_d = irt_pkg::S_NS_A;
      irt_pkg::S_NS_A: state_d = irt_pkg::S_NE_M;
      irt_pkg::S_NE_M: state_d = irt_pkg::S_NE_A;
      irt_pkg::S_NE_A: state_d = irt_pkg::S_INS_CHK;
      irt_pkg::S_INS_CHK: begin
        if (ins_late || cnt_q >= CNT_W'(MAX_ENTRIES)) state_d = irt_pkg::S_RESP;
        else state_d = irt_pkg::S_SCAN_RD;
      end
      irt_pkg::S_SCAN_RD: state_d = (idx_q == cnt_q) ? irt_pkg::S_SH_RD
                                                      : irt_pkg::S_SCAN_LD;
      irt_pkg::S_SCAN_LD: state_d = irt_pkg::S_BS_M;
      irt_pkg::S_BS_M: state_d = irt_pkg::S_BS_A;
      irt_pkg::S_BS_A: state_d = (rq_q.req_type == irt_pkg::REQ_PURGE) ?
                                 irt_pkg::S_PG_CMP : irt_pkg::S_BE_M;
      irt_pkg::S_BE_M: state_d = irt_pkg::S_BE_A;
      irt_pkg::S_BE_A: state_d = irt_pkg::S_SCAN_CMP;
      irt_pkg::S_SCAN_CMP: begin
        if (ovl) state_d = irt_pkg::S_RESP;
        else if (before_b && prev_ok) state_d = irt_pkg::S_SH_RD;
        else state_d = irt_pkg::S_SCAN_RD;
      end
      irt_pkg::S_SH_RD: state_d = (k_q == pos_q) ? irt_pkg::S_INS_WR : irt_pkg::S_SH_WR;
      irt_pkg::S_SH_WR: state_d = irt_pkg::S_SH_RD;
      irt_pkg::S_INS_WR: state_d = irt_pkg::S_RESP;
      irt_pkg::S_FIND_RD: state_d = (idx_q == cnt_q) ? irt_pkg::S_RESP
                                                      : irt_pkg::S_FIND_LD;
      irt_pkg::S_FIND_LD: begin
        if (!ref_hit) state_d = irt_pkg::S_FIND_RD;
        else if (rq_q.req_type == irt_pkg::REQ_LOOKUP) state_d = irt_pkg::S_RESP;
        else state_d = irt_pkg::S_RM_RD;
      end
      irt_pkg::S_RM_RD: begin
        if (k_next >= {1'b0, cnt_q}) begin
          state_d = (rq_q.req_type == irt_pkg::REQ_PURGE) ? irt_pkg::S_PG_CHK
                                                          : irt_pkg::S_RESP;
        end else begin
          state_d = irt_pkg::S_RM_WR;
        end
      end
      irt_pkg::S_RM_WR: state_d = irt_pkg::S_RM_RD;
      irt_pkg::S_RD_RD: state_d = read_ok ? irt_pkg::S_RD_LD : irt_pkg::S_RESP;
      irt_pkg::S_RD_LD: state_d = irt_pkg::S_RESP;
      irt_pkg::S_PG_CHK: state_d = (cnt_q == '0) ? irt_pkg::S_RESP : irt_pkg::S_PG_LD;
      irt_pkg::S_PG_LD: state_d = irt_pkg::S_BS_M;
      irt_pkg::S_PG_CMP: state_d = purge_late ? irt_pkg::S_RM_RD : irt_pkg::S_RESP;
      irt_pkg::S_RESP: if (rsp_o.ready) state_d = irt_pkg::S_IDLE;
      default: state_d = irt_pkg::S_IDLE;
    endcase
  end

  // outputs: RAM port, count update, result
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = k_q[IDX_W-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_q[IDX_W-1:0];
    cnt_d      = cnt_q;
    res_load   = 1'b0;
    res_status = irt_pkg::ST_OK;
    res_idx    = '0;
    res_ent    = '0;
    case (state_q)
      irt_pkg::S_IDLE: begin
        if (req_i.valid && req_i.data.req_type > irt_pkg::REQ_PURGE) res_load = 1'b1;
      end
      irt_pkg::S_INS_CHK: begin
        if (ins_late) begin
          res_load   = 1'b1;
          res_status = irt_pkg::ST_TOO_LATE;
          res_ent    = new_ent;
        end else if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
          res_load   = 1'b1;
          res_status = irt_pkg::ST_FULL;
        end
      end
      irt_pkg::S_SCAN_CMP: begin
        if (ovl) begin
          res_load   = 1'b1;
          res_status = irt_pkg::ST_CONFLICT;
          res_idx    = 6'(idx_q);
          res_ent    = ent_q;
        end
      end
      irt_pkg::S_SH_RD: ram_raddr = IDX_W'(k_q - 1'b1);
      irt_pkg::S_SH_WR: ram_we = 1'b1;
      irt_pkg::S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q[IDX_W-1:0];
        ram_wdata  = new_ent;
        cnt_d      = cnt_q + 1'b1;
        res_load   = 1'b1;
        res_idx    = 6'(pos_q);
        res_ent    = new_ent;
      end
      irt_pkg::S_FIND_RD: begin
        if (idx_q == cnt_q) begin
          res_load   = 1'b1;
          res_status = irt_pkg::ST_NOT_FOUND;
        end
      end
      irt_pkg::S_FIND_LD: begin
        if (ref_hit && rq_q.req_type == irt_pkg::REQ_LOOKUP) begin
          res_load = 1'b1;
          res_idx  = 6'(idx_q);
          res_ent  = ram_rdata;
        end
      end
      irt_pkg::S_RM_RD: begin
        ram_raddr = IDX_W'(k_next);
        if (k_next >= {1'b0, cnt_q}) begin
          cnt_d = cnt_q - 1'b1;
          if (rq_q.req_type != irt_pkg::REQ_PURGE) begin
            res_load = 1'b1;
            res_idx  = 6'(idx_q);
            res_ent  = ent_q;
          end
        end
      end
      irt_pkg::S_RM_WR: ram_we = 1'b1;
      irt_pkg::S_RD_RD: begin
        ram_raddr = IDX_W'(sidx_w);
        if (!read_ok) begin
          res_load   = 1'b1;
          res_status = irt_pkg::ST_NOT_FOUND;
          res_idx    = rq_q.slot_index;
        end
      end
      irt_pkg::S_RD_LD: begin
        res_load = 1'b1;
        res_idx  = rq_q.slot_index;
        res_ent  = ram_rdata;
      end
      irt_pkg::S_PG_CHK: begin
        ram_raddr = '0;
        if (cnt_q == '0) res_load = 1'b1;
      end
      irt_pkg::S_PG_CMP: if (!purge_late) res_load = 1'b1;
      default: ;
    endcase
  end

  irt_ram #(
    .Width(ENT_W),
    .Depth(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irt_pkg::S_IDLE;
      cnt_q   <= '0;
      lead_q  <= irt_pkg::LEAD_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) lead_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == irt_pkg::S_IDLE && req_i.valid) begin
      rq_q  <= req_i.data;
      idx_q <= '0;
    end
    case (state_q)
      irt_pkg::S_NOW_A: now_q <= lin_sum;
      irt_pkg::S_NS_A:  ns_q  <= lin_sum;
      irt_pkg::S_NE_A:  ne_q  <= lin_sum;
      irt_pkg::S_BS_A:  bs_q  <= lin_sum;
      irt_pkg::S_BE_A:  be_q  <= lin_sum;
      irt_pkg::S_INS_CHK: begin
        pos_q <= cnt_q;
        idx_q <= '0;
      end
      irt_pkg::S_SCAN_RD: k_q <= cnt_q;
      irt_pkg::S_SCAN_LD, irt_pkg::S_PG_LD, irt_pkg::S_FIND_LD: ent_q <= ram_rdata;
      irt_pkg::S_SCAN_CMP: begin
        if (before_b && prev_ok) begin
          pos_q <= idx_q;
        end else begin
          prev_be_q <= be_q;
          idx_q     <= idx_q + 1'b1;
        end
      end
      irt_pkg::S_SH_WR: k_q <= k_q - 1'b1;
      default: ;
    endcase
    if (state_q == irt_pkg::S_FIND_LD) begin
      if (ref_hit) k_q <= idx_q;
      else idx_q <= idx_q + 1'b1;
    end
    if (state_q == irt_pkg::S_RM_WR) k_q <= CNT_W'(k_next);
    if (state_q == irt_pkg::S_PG_CMP) k_q <= '0;
    if (res_load) begin
      rsp_q.status        <= res_status;
      rsp_q.found_index   <= res_idx;
      rsp_q.out_ref       <= res_ent.ref_id;
      rsp_q.out_start_day <= res_ent.start_day;
      rsp_q.out_start_ms  <= res_ent.start_ms;
      rsp_q.out_stop_day  <= res_ent.stop_day;
      rsp_q.out_stop_ms   <= res_ent.stop_ms;
      rsp_q.entry_count   <= 7'(cnt_d);
    end
  end

  `IRT_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_ENTRIES))
  `IRT_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  `IRT_ASSERT_IMP(a_write_in_table, clk_i, rst_ni, ram_we, CNT_W'(ram_waddr) <= cnt_q)
endmodule
